// File: rtl/core/humidity_temp_frame_decoder_top_assert.svh
// Assertion macros used by the frame decoder top-level RTL.
// Needs nothing else; files that check their own logic include this header.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define HTFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htfd: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define HTFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htfd: next-cycle check failed");

`endif

// File: rtl/core/htfd_pkg.sv
// Shared types and constants of the humidity and temperature frame decoder.
// No dependencies; every RTL module imports this package.
package htfd_pkg;

    localparam int HTFD_RAW_W   = 20;
    localparam int HTFD_HUM_W   = 14;
    localparam int HTFD_TEMP_W  = 15;
    localparam int HTFD_FRAC_W  = 20;

    typedef logic [7:0]               t_byte;
    typedef logic [2:0]               t_pos;
    typedef logic [HTFD_RAW_W-1:0]    t_raw;
    typedef logic [HTFD_HUM_W-1:0]    t_hum_centi;
    typedef logic signed [HTFD_TEMP_W-1:0] t_temp_centi;

    localparam t_byte HTFD_CRC_POLY   = 8'h31;
    localparam t_byte HTFD_CRC_INIT   = 8'hFF;
    localparam t_pos  HTFD_FINAL_POS  = 3'd6;
    localparam int    HTFD_BUSY_BIT   = 7;
    localparam int    HTFD_CALIB_BIT  = 3;

    // Fixed-point scale factors: value = (raw * scale) >> 20, minus the offset for temperature.
    localparam logic [13:0] HTFD_HUM_SCALE   = 14'd10000;
    localparam logic [14:0] HTFD_TEMP_SCALE  = 15'd20000;
    localparam logic [14:0] HTFD_TEMP_OFFSET = 15'd5000;

    localparam logic HTFD_STATUS_OK      = 1'b0;
    localparam logic HTFD_STATUS_CRC_ERR = 1'b1;

endpackage

// File: rtl/core/htfd_crc8.sv
// One-byte update of the CRC-8 (polynomial 0x31, MSB first, no reflection).
// Depends on htfd_pkg.
module htfd_crc8 (
    input  htfd_pkg::t_byte i_crc,
    input  htfd_pkg::t_byte i_data,
    output htfd_pkg::t_byte o_crc
);
    import htfd_pkg::*;

    always_comb begin
        t_byte c;
        c = i_crc ^ i_data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ HTFD_CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// File: rtl/core/htfd_convert.sv
// Scales the raw humidity and temperature counts to hundredths of a unit.
// Depends on htfd_pkg.
module htfd_convert (
    input  htfd_pkg::t_raw        i_humidity_raw,
    input  htfd_pkg::t_raw        i_temperature_raw,
    output htfd_pkg::t_hum_centi  o_humidity_centipct,
    output htfd_pkg::t_temp_centi o_temperature_centideg
);
    import htfd_pkg::*;

    localparam int HUM_PROD_W  = HTFD_RAW_W + HTFD_HUM_W;
    localparam int TEMP_PROD_W = HTFD_RAW_W + HTFD_TEMP_W;

    logic [HUM_PROD_W-1:0]  hum_prod;
    logic [TEMP_PROD_W-1:0] temp_prod;
    logic [HTFD_TEMP_W-1:0] temp_scaled;

    assign hum_prod  = HUM_PROD_W'(i_humidity_raw) * HUM_PROD_W'(HTFD_HUM_SCALE);
    assign temp_prod = TEMP_PROD_W'(i_temperature_raw) * TEMP_PROD_W'(HTFD_TEMP_SCALE);

    // Floor of the product over 2^20 is just the upper bits.
    assign o_humidity_centipct = hum_prod[HUM_PROD_W-1:HTFD_FRAC_W];
    assign temp_scaled         = temp_prod[TEMP_PROD_W-1:HTFD_FRAC_W];

    // The true result lies in -5000..14999, so wrapping 15-bit subtraction is exact.
    assign o_temperature_centideg = t_temp_centi'(temp_scaled - HTFD_TEMP_OFFSET);

endmodule

// File: rtl/core/humidity_temp_frame_decoder_top.sv
// Sensor measurement frame decoder: byte capture, CRC check, unpack and scaling.
// Depends on htfd_pkg, htfd_crc8, htfd_convert and the assertion macro header.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one reply byte per
//   transfer, with i_frame_start high on byte 0. Bytes 0 to 5 are held and run
//   through the CRC-8; byte 6 is the CRC. The transfer of byte 6 yields one
//   result on the output channel (o_out_valid / i_out_ready); bytes 0 to 5
//   yield none. A frame start in mid-frame drops the partial frame.
//   Latency: the result is valid in the cycle after byte 6 is transferred.
//   Throughput: one byte per cycle while o_in_ready is high; CRC update and
//   capture are registered; the output register reloads in the cycle it drains.
//   On a CRC mismatch all values and flags are zero and o_frame_status is 1.
//   When the receiver stalls, the output register holds its result and
//   o_in_ready drops until the result is taken.
//   Reset (synchronous, active low) empties the output register, sets the
//   byte position to 0 and the CRC to 0xFF; held bytes are not cleared.
`include "humidity_temp_frame_decoder_top_assert.svh"

module humidity_temp_frame_decoder_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  htfd_pkg::t_byte       i_rx_byte,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output htfd_pkg::t_raw        o_humidity_raw,
    output htfd_pkg::t_raw        o_temperature_raw,
    output htfd_pkg::t_hum_centi  o_humidity_centipct,
    output htfd_pkg::t_temp_centi o_temperature_centideg,
    output logic                  o_busy_flag,
    output logic                  o_calibrated_flag,
    output logic                  o_frame_status
);
    import htfd_pkg::*;

    t_byte       r_crc, n_crc;
    t_pos        r_pos, n_pos;
    t_byte       r_bytes [HTFD_FINAL_POS];
    logic        r_out_valid;
    t_raw        r_hum_raw, r_tmp_count;
    t_hum_centi  r_hum_centi;
    t_temp_centi r_temp_centi;
    logic        r_busy, r_calib, r_status;

    logic        in_fire;
    logic        out_free;
    t_pos        eff_pos;
    t_byte       eff_crc;
    t_byte       crc_upd;
    logic        is_final;
    logic        crc_ok;
    t_raw        hum_raw, tmp_count;
    t_hum_centi  hum_centi;
    t_temp_centi temp_centi;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // A frame start, or a position past the CRC byte, restarts the frame.
    assign eff_pos  = (i_frame_start || r_pos > HTFD_FINAL_POS) ? '0 : r_pos;
    assign eff_crc  = (i_frame_start || r_pos > HTFD_FINAL_POS) ? HTFD_CRC_INIT : r_crc;
    assign is_final = (eff_pos == HTFD_FINAL_POS);
    assign crc_ok   = (eff_crc == i_rx_byte);

    htfd_crc8 u_crc8 (
        .i_crc  (eff_crc),
        .i_data (i_rx_byte),
        .o_crc  (crc_upd)
    );

    assign hum_raw   = {r_bytes[1], r_bytes[2], r_bytes[3][7:4]};
    assign tmp_count = {r_bytes[3][3:0], r_bytes[4], r_bytes[5]};

    htfd_convert u_convert (
        .i_humidity_raw         (hum_raw),
        .i_temperature_raw      (tmp_count),
        .o_humidity_centipct    (hum_centi),
        .o_temperature_centideg (temp_centi)
    );

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        if (in_fire) begin
            if (is_final) begin
                n_pos = '0;
                n_crc = HTFD_CRC_INIT;
            end else begin
                n_pos = eff_pos + 3'd1;
                n_crc = crc_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= HTFD_CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            if (in_fire && is_final) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Held bytes and result payload carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire && !is_final) begin
            r_bytes[eff_pos] <= i_rx_byte;
        end
        if (in_fire && is_final) begin
            if (crc_ok) begin
                r_hum_raw    <= hum_raw;
                r_tmp_count  <= tmp_count;
                r_hum_centi  <= hum_centi;
                r_temp_centi <= temp_centi;
                r_busy       <= r_bytes[0][HTFD_BUSY_BIT];
                r_calib      <= r_bytes[0][HTFD_CALIB_BIT];
                r_status     <= HTFD_STATUS_OK;
            end else begin
                r_hum_raw    <= '0;
                r_tmp_count  <= '0;
                r_hum_centi  <= '0;
                r_temp_centi <= '0;
                r_busy       <= 1'b0;
                r_calib      <= 1'b0;
                r_status     <= HTFD_STATUS_CRC_ERR;
            end
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_humidity_raw         = r_hum_raw;
    assign o_temperature_raw      = r_tmp_count;
    assign o_humidity_centipct    = r_hum_centi;
    assign o_temperature_centideg = r_temp_centi;
    assign o_busy_flag            = r_busy;
    assign o_calibrated_flag      = r_calib;
    assign o_frame_status         = r_status;

    `HTFD_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= HTFD_FINAL_POS)
    `HTFD_ASSERT_NXT(a_final_loads_result, i_clk, i_rst_n, in_fire && is_final,
        r_out_valid && r_pos == 3'd0 && r_crc == HTFD_CRC_INIT)
    `HTFD_ASSERT_NXT(a_start_is_byte0, i_clk, i_rst_n, in_fire && i_frame_start,
        r_pos == 3'd1)
    `HTFD_ASSERT_IMP(a_error_zeroes, i_clk, i_rst_n, r_out_valid && r_status,
        r_hum_raw == '0 && r_tmp_count == '0 && !r_busy && !r_calib)

endmodule
